// File: hdl/gtg_pkg.sv
package gtg_pkg;

   localparam int MAX_STAGES = 24;

   localparam logic signed [24:0] PI_Q20      = 25'sd3294199;
   localparam logic signed [24:0] TWO_PI_Q20  = 25'sd6588398;
   localparam logic signed [24:0] HALF_PI_Q20 = 25'sd1647099;
   localparam logic signed [30:0] INV_K_Q30   = 31'sd652032874;

   localparam logic [2:0] CSR_GOAL_X       = 3'd0;
   localparam logic [2:0] CSR_GOAL_Y       = 3'd1;
   localparam logic [2:0] CSR_GOAL_ENABLE  = 3'd2;
   localparam logic [2:0] CSR_LINEAR_GAIN  = 3'd3;
   localparam logic [2:0] CSR_ANGULAR_GAIN = 3'd4;
   localparam logic [2:0] CSR_DIST_THRESH  = 3'd5;

   typedef struct packed {
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic signed [15:0] heading;
   } req_type;

   typedef struct packed {
      logic [14:0]        linear_speed;
      logic signed [15:0] angular_speed;
   } rsp_type;

   // Vectoring (v*) and rotation (r*) datapaths travel side by side.
   typedef struct packed {
      logic               valid;
      logic               zero;
      logic signed [15:0] heading;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [23:0] vz;
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [23:0] ra;
   } cell_type;

   function automatic logic signed [23:0] atan_q20(input logic [4:0] idx);
      logic signed [23:0] r;
      case (idx)
         5'd0:  r = 24'sd823550;
         5'd1:  r = 24'sd486170;
         5'd2:  r = 24'sd256879;
         5'd3:  r = 24'sd130396;
         5'd4:  r = 24'sd65451;
         5'd5:  r = 24'sd32757;
         5'd6:  r = 24'sd16383;
         5'd7:  r = 24'sd8192;
         5'd8:  r = 24'sd4096;
         5'd9:  r = 24'sd2048;
         5'd10: r = 24'sd1024;
         5'd11: r = 24'sd512;
         5'd12: r = 24'sd256;
         5'd13: r = 24'sd128;
         5'd14: r = 24'sd64;
         5'd15: r = 24'sd32;
         5'd16: r = 24'sd16;
         5'd17: r = 24'sd8;
         5'd18: r = 24'sd4;
         5'd19: r = 24'sd2;
         5'd20: r = 24'sd1;
         default: r = 24'sd0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/gtg_pre.sv
module gtg_pre
   import gtg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  req_type            req,
   input  logic signed [15:0] goal_x,
   input  logic signed [15:0] goal_y,
   output cell_type           cell_out
);

   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic signed [31:0] sx;
   logic signed [31:0] sy;
   logic signed [24:0] a0;
   logic signed [24:0] a1;
   logic signed [24:0] a2;
   cell_type           cell_in;
   cell_type           cell_ff;

   always_comb begin
      dx = {goal_x[15], goal_x} - {req.pose_x[15], req.pose_x};
      dy = {goal_y[15], goal_y} - {req.pose_y[15], req.pose_y};
      sx = {{3{dx[16]}}, dx, 12'b0};
      sy = {{3{dy[16]}}, dy, 12'b0};

      cell_in.valid   = accept;
      cell_in.zero    = (dx == 17'sd0) && (dy == 17'sd0);
      cell_in.heading = req.heading;

      // Bring the offset into the right half plane before vectoring.
      cell_in.vx = sx;
      cell_in.vy = sy;
      cell_in.vz = 24'sd0;
      if (sx < 32'sd0) begin
         if (sy >= 32'sd0) begin
            cell_in.vx = sy;
            cell_in.vy = -sx;
            cell_in.vz = HALF_PI_Q20[23:0];
         end else begin
            cell_in.vx = -sy;
            cell_in.vy = sx;
            cell_in.vz = -HALF_PI_Q20[23:0];
         end
      end

      // The heading spans at most one extra turn, so one correction suffices.
      a0 = -{req.heading[15], req.heading, 8'b0};
      if (a0 > PI_Q20) begin
         a1 = a0 - TWO_PI_Q20;
      end else if (a0 < -PI_Q20) begin
         a1 = a0 + TWO_PI_Q20;
      end else begin
         a1 = a0;
      end

      cell_in.rx = sx;
      cell_in.ry = sy;
      a2 = a1;
      if (a1 > HALF_PI_Q20) begin
         cell_in.rx = -sy;
         cell_in.ry = sx;
         a2 = a1 - HALF_PI_Q20;
      end else if (a1 < -HALF_PI_Q20) begin
         cell_in.rx = sy;
         cell_in.ry = -sx;
         a2 = a1 + HALF_PI_Q20;
      end
      cell_in.ra = a2[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// File: hdl/gtg_cell.sv
module gtg_cell
   import gtg_pkg::*;
#(
   parameter int SHIFT = 0
)
(
   input  logic     clock,
   input  logic     reset,
   input  cell_type prev,
   output cell_type cell_out
);

   localparam logic [4:0]         IDX  = 5'(SHIFT);
   localparam logic signed [23:0] ATAN = atan_q20(IDX);

   cell_type cell_in;
   cell_type cell_ff;

   always_comb begin
      cell_in = prev;
      if (prev.vy < 32'sd0) begin
         cell_in.vx = prev.vx - (prev.vy >>> SHIFT);
         cell_in.vy = prev.vy + (prev.vx >>> SHIFT);
         cell_in.vz = prev.vz - ATAN;
      end else begin
         cell_in.vx = prev.vx + (prev.vy >>> SHIFT);
         cell_in.vy = prev.vy - (prev.vx >>> SHIFT);
         cell_in.vz = prev.vz + ATAN;
      end
      if (prev.ra >= 24'sd0) begin
         cell_in.rx = prev.rx - (prev.ry >>> SHIFT);
         cell_in.ry = prev.ry + (prev.rx >>> SHIFT);
         cell_in.ra = prev.ra - ATAN;
      end else begin
         cell_in.rx = prev.rx + (prev.ry >>> SHIFT);
         cell_in.ry = prev.ry - (prev.rx >>> SHIFT);
         cell_in.ra = prev.ra + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// File: hdl/go_to_goal_controller.sv
// Proportional go-to-goal steering for a unicycle robot. Every pose transaction
// taken while goal_enable is set yields one speed result after it passes the
// preprocessing register, the CORDIC cell chain and the output stages; with
// goal_enable clear the pose is dropped. A new pose may be offered every cycle
// and busy never rises: the depth of the CORDIC cell chain (one vectoring and
// one rotation iteration per cell) sets the latency, not the rate. rsp_valid is
// high for a single cycle and the receiver cannot stall it. Write the registers
// only while no transaction is in flight.
module go_to_goal_controller
   import gtg_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int N   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int LAT = N + 4;

   logic signed [15:0] goal_x_ff;
   logic signed [15:0] goal_y_ff;
   logic               goal_enable_ff;
   logic [15:0]        linear_gain_ff;
   logic [15:0]        angular_gain_ff;
   logic [14:0]        dist_thresh_ff;

   logic     accept_go;
   cell_type chain [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff       <= 16'sd0;
         goal_y_ff       <= 16'sd0;
         goal_enable_ff  <= 1'b0;
         linear_gain_ff  <= 16'd13107;
         angular_gain_ff <= 16'd32768;
         dist_thresh_ff  <= 15'd26;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GOAL_X:       goal_x_ff       <= csr_wdata;
            CSR_GOAL_Y:       goal_y_ff       <= csr_wdata;
            CSR_GOAL_ENABLE:  goal_enable_ff  <= csr_wdata[0];
            CSR_LINEAR_GAIN:  linear_gain_ff  <= csr_wdata;
            CSR_ANGULAR_GAIN: angular_gain_ff <= csr_wdata;
            CSR_DIST_THRESH:  dist_thresh_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   assign busy      = 1'b0;
   assign accept_go = start && !busy && goal_enable_ff;

   gtg_pre u_pre (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept_go),
      .req      (req_payload),
      .goal_x   (goal_x_ff),
      .goal_y   (goal_y_ff),
      .cell_out (chain[0])
   );

   for (genvar j = 0; j < N; j++) begin : g_cell
      gtg_cell #(.SHIFT(j)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .prev     (chain[j]),
         .cell_out (chain[j+1])
      );
   end

   // Stage one: angular error, the angular gain product and the CORDIC gain correction of the projection.
   logic signed [23:0] bearing;
   logic signed [25:0] ang_err;
   logic signed [42:0] ang_prod_in;
   logic signed [42:0] ang_prod_ff;
   logic signed [62:0] lin_prod_in;
   logic signed [62:0] lin_prod_ff;
   logic               s1_valid_ff;

   always_comb begin
      bearing     = chain[N].zero ? 24'sd0 : chain[N].vz;
      ang_err     = {{2{bearing[23]}}, bearing}
                  - {{2{chain[N].heading[15]}}, chain[N].heading, 8'b0};
      ang_prod_in = $signed({1'b0, angular_gain_ff}) * ang_err;
      lin_prod_in = chain[N].rx * INV_K_Q30;
   end

   always_ff @(posedge clock) begin
      ang_prod_ff <= ang_prod_in;
      lin_prod_ff <= lin_prod_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= chain[N].valid;
      end
   end

   // Stage two: round, scale and saturate the turn rate; scale the projection.
   logic signed [43:0] ang_sum;
   logic signed [19:0] ang_wide;
   logic signed [15:0] ang_in;
   logic signed [15:0] ang_ff;
   logic signed [63:0] lin_sum;
   logic signed [21:0] lin_in;
   logic signed [21:0] lin_ff;
   logic               s2_valid_ff;

   always_comb begin
      ang_sum  = {ang_prod_ff[42], ang_prod_ff} + 44'sd8388608;
      ang_wide = ang_sum[43:24];
      if (ang_wide > 20'sd32767) begin
         ang_in = 16'sd32767;
      end else if (ang_wide < -20'sd32768) begin
         ang_in = -16'sd32768;
      end else begin
         ang_in = ang_wide[15:0];
      end
      lin_sum = {lin_prod_ff[62], lin_prod_ff} + 64'sd2199023255552;
      lin_in  = lin_sum[63:42];
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
      lin_ff <= lin_in;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage three: threshold, forward speed and the output register.
   logic signed [38:0] spd_prod;
   logic signed [39:0] spd_sum;
   logic signed [23:0] spd_wide;
   logic               above;
   rsp_type            rsp_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   always_comb begin
      above    = lin_ff > $signed({7'b0, dist_thresh_ff});
      spd_prod = $signed({1'b0, linear_gain_ff}) * lin_ff;
      spd_sum  = {spd_prod[38], spd_prod} + 40'sd32768;
      spd_wide = spd_sum[39:16];
      rsp_in.angular_speed = ang_ff;
      if (!above || spd_wide < 24'sd0) begin
         rsp_in.linear_speed = 15'd0;
      end else if (spd_wide > 24'sd32767) begin
         rsp_in.linear_speed = 15'd32767;
      end else begin
         rsp_in.linear_speed = spd_wide[14:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A result only ever follows an enabled pose by the full pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept_go, LAT))
      else $error("result without an enabled pose at the pipeline depth");

   // Forward motion only when the scaled projection cleared the threshold.
   a_threshold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.linear_speed != 15'd0)
         |-> ($past(lin_ff) > $signed({7'b0, dist_thresh_ff})))
      else $error("linear speed given at or below the distance threshold");

   // A pose offered while disabled never starts a transaction.
   a_disabled: assert property (@(posedge clock) disable iff (reset)
      !goal_enable_ff |=> !chain[0].valid)
      else $error("pose entered the pipeline while disabled");

endmodule
